// ===== rtl/bal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list: request codes,
// result status codes, the per-cell shift command and the controller states.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Field widths of the request and result transfers.
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int CNT_OUT_W = 5;

    // A display shows at most this many entries.
    localparam int RES_LIMIT = 16;

    // Request codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND   = 3'd0,
        FN_INSERT   = 3'd1,
        FN_DEL_LAST = 3'd2,
        FN_DEL_AT   = 3'd3,
        FN_SHOW     = 3'd4
    } func_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_ROTATE = 3'd4
    } cell_op_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } state_t;

endpackage

// ===== rtl/bal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_cell
// One storage cell of the list chain. It holds the entry at its own index and
// decides from the broadcast command whether to keep it, load the new word,
// take the lower neighbor (open a gap), take the upper neighbor (close a gap)
// or take the head entry (wrap-around during a display rotation).
// ----------------------------------------------------------------------------
module bal_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  logic                                       clk,
    input  bal_pkg::cell_op_t                          op,
    input  logic [bal_pkg::POS_W-1:0]                  pos,
    input  logic [$clog2(CAPACITY+1)-1:0]              count,
    input  logic [bal_pkg::WORD_W-1:0]                 word,
    input  logic [bal_pkg::WORD_W-1:0]                 lower,
    input  logic [bal_pkg::WORD_W-1:0]                 upper,
    input  logic [bal_pkg::WORD_W-1:0]                 first,
    output logic [bal_pkg::WORD_W-1:0]                 data
);
    import bal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > POS_W + 1) ? CW : POS_W + 1;

    localparam logic [LW-1:0] IDX_V = LW'(IDX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [LW-1:0]     pos_ext;
    logic [LW-1:0]     cnt_ext;

    assign pos_ext = LW'(pos);
    assign cnt_ext = LW'(count);

    // Pick the next content of this cell from the command and its index.
    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_APPEND:
            begin
                if (IDX_V == cnt_ext)
                    data_next = word;
            end
            CELL_INSERT:
            begin
                if (IDX_V == pos_ext)
                    data_next = word;
                else if (IDX_V > pos_ext && IDX_V <= cnt_ext)
                    data_next = lower;
            end
            CELL_DELETE:
            begin
                if (IDX_V >= pos_ext && IDX_V + LW'(1) < cnt_ext)
                    data_next = upper;
            end
            CELL_ROTATE:
            begin
                if (IDX_V + LW'(1) < cnt_ext)
                    data_next = upper;
                else if (IDX_V + LW'(1) == cnt_ext)
                    data_next = first;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/bounded_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of up to CAPACITY signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// A request (func, position, word_in) is a transfer on in_valid/in_ready.
// Results are transfers on out_valid/out_ready, each carrying status,
// word_out, slot, entries_now and final_item; final_item marks the last
// result of a request.
// Append, insert, delete-last, delete-at-index, a rejected request and the
// display of an empty list each give one result, which sits in the output
// register in the cycle after the request transfer.
// Edits update the cells of the chain together from one broadcast command;
// delete-last only lowers the count. A display of a non-empty list rotates
// the chain one cell per cycle, held while a shown entry waits at a stalled
// receiver, and shows the head cell while within the limit; at most the first 16
// entries are shown, the remaining rotations restore the original order.
// in_ready is high only when no display is running and the output register
// is empty or being emptied, so one request is in work at a time.
// A stalled receiver holds the result in the output register and freezes
// the display rotation while entries remain to be shown. Reset empties the
// list and the output register; entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_list #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bal_pkg::FUNC_W-1:0]            func,
    input  logic [bal_pkg::POS_W-1:0]             position,
    input  logic signed [bal_pkg::WORD_W-1:0]     word_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bal_pkg::STAT_W-1:0]            status,
    output logic signed [bal_pkg::WORD_W-1:0]     word_out,
    output logic [bal_pkg::SLOT_W-1:0]            slot,
    output logic [bal_pkg::CNT_OUT_W-1:0]         entries_now,
    output logic                                  final_item
);
    import bal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    localparam logic [LW-1:0] CAP_V   = LW'(CAPACITY);
    localparam logic [LW-1:0] LIMIT_V = LW'(RES_LIMIT);

    // Controller state.
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rot_reg, rot_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_OUT_W-1:0] cnt_out_reg, cnt_out_next;
    logic                 final_reg, final_next;

    // Chain wiring.
    cell_op_t          cell_op;
    logic [WORD_W-1:0] cell_data [CAPACITY];

    logic          accept;
    logic          out_free;
    logic [LW-1:0] cnt_ext;
    logic [LW-1:0] pos_ext;
    logic [LW-1:0] rot_ext;
    logic [LW-1:0] show_n;
    logic          emit;
    logic [LW-1:0] new_cnt_ext;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign cnt_ext  = LW'(count_reg);
    assign pos_ext  = LW'(position);
    assign rot_ext  = LW'(rot_reg);
    assign show_n   = (cnt_ext < LIMIT_V) ? cnt_ext : LIMIT_V;
    assign emit     = rot_ext < LIMIT_V;

    // Chain of cells, each handing its entry to its neighbors.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_W-1:0] lower_w;
        logic [WORD_W-1:0] upper_w;

        if (g == 0)
        begin : g_low_end
            assign lower_w = '0;
        end
        else
        begin : g_low_link
            assign lower_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_high_end
            assign upper_w = cell_data[g];
        end
        else
        begin : g_high_link
            assign upper_w = cell_data[g+1];
        end

        bal_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .pos   (position),
            .count (count_reg),
            .word  (word_in),
            .lower (lower_w),
            .upper (upper_w),
            .first (cell_data[0]),
            .data  (cell_data[g])
        );
    end

    // Request decode, display sequencing and output register loading.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rot_next       = rot_reg;
        cell_op        = CELL_HOLD;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        word_next      = word_reg;
        slot_next      = slot_reg;
        cnt_out_next   = cnt_out_reg;
        final_next     = final_reg;
        new_cnt_ext    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    unique case (func)
                        FN_APPEND:
                        begin
                            if (cnt_ext >= CAP_V)
                                status_next = STAT_FULL;
                            else
                            begin
                                cell_op    = CELL_APPEND;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_INSERT:
                        begin
                            if (cnt_ext >= CAP_V)
                                status_next = STAT_FULL;
                            else if (pos_ext >= cnt_ext)
                                status_next = STAT_RANGE;
                            else
                            begin
                                cell_op    = CELL_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_DEL_LAST:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_EMPTY;
                            else
                                count_next = count_reg - CW'(1);
                        end
                        FN_DEL_AT:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_EMPTY;
                            else if (pos_ext >= cnt_ext)
                                status_next = STAT_RANGE;
                            else
                            begin
                                cell_op    = CELL_DELETE;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        FN_SHOW:
                        begin
                            if (count_reg == '0)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                state_next = ST_SHOW;
                                rot_next   = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase

                    // A non-empty display delivers its results from ST_SHOW.
                    if (!(func == FN_SHOW && count_reg != '0))
                    begin
                        new_cnt_ext    = LW'(count_next);
                        out_valid_next = 1'b1;
                        word_next      = '0;
                        slot_next      = '0;
                        cnt_out_next   = new_cnt_ext[CNT_OUT_W-1:0];
                        final_next     = 1'b1;
                    end
                end
            end
            ST_SHOW:
            begin
                // Rotate by one; show the head cell while within the limit.
                if (out_free || !emit)
                begin
                    cell_op  = CELL_ROTATE;
                    rot_next = rot_reg + CW'(1);
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STAT_OK;
                        word_next      = cell_data[0];
                        slot_next      = rot_ext[SLOT_W-1:0];
                        cnt_out_next   = cnt_ext[CNT_OUT_W-1:0];
                        final_next     = (rot_ext + LW'(1) == show_n);
                    end
                    if (rot_ext + LW'(1) == cnt_ext)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        word_reg    <= word_next;
        slot_reg    <= slot_next;
        cnt_out_reg <= cnt_out_next;
        final_reg   <= final_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign word_out    = word_reg;
    assign slot        = slot_reg;
    assign entries_now = cnt_out_reg;
    assign final_item  = final_reg;

`ifndef ASSERT_OFF
    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= CAP_V)
        else $error("entry count above capacity");

    // The entry count only changes on an accepted request.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // A display never runs on an empty list.
    a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHOW |-> count_reg != '0)
        else $error("display running on an empty list");

    // The rotation counter stays below the entry count during a display.
    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHOW |-> rot_reg < count_reg)
        else $error("display rotation past the list end");
`endif

endmodule
